FILE: rtl/core/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // Fixed field widths
    localparam int VAL_W      = 16;   // Q4.12 operand
    localparam int PROD_W     = 32;   // Q8.24 product
    localparam int ACC_W      = 48;   // Q24.24 accumulator
    localparam int ROW_W      = 16;   // row index and row count
    localparam int VEC_LEN_W  = 13;   // vec_len register
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;

    // Opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    // Classified command handed from front to back (address travels beside it)
    typedef struct packed {
        logic             op;        // OP_LOAD or OP_WEIGHT
        logic             first;     // first column of a row: restart the sum
        logic             row_end;   // last column of a row: emit a result
        logic             last;      // final row of the matrix
        logic [ROW_W-1:0] row_idx;
        logic [VAL_W-1:0] value;
    } cmd_t;

endpackage

FILE: rtl/core/mvm_ram.sv
// ----------------------------------------------------------------------------
// mvm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/mvm_front.sv
// ----------------------------------------------------------------------------
// mvm_front
// Accepts items, tracks load pointer, column and row, and classifies each
// item into a command for the back end.
// ----------------------------------------------------------------------------
module mvm_front #(
    parameter int MAX_N    = 4096,
    parameter int MAX_ROWS = 65535
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // item channel
    input  logic                                       item_valid,
    output logic                                       item_stall,
    input  logic                                       opcode,
    input  logic signed [mvm_pkg::VAL_W-1:0]           elem_value,
    // configuration
    input  logic [mvm_pkg::VEC_LEN_W-1:0]              vec_len,
    input  logic [mvm_pkg::ROW_W-1:0]                  row_count,
    // queue push side
    input  logic                                       queue_full,
    output logic                                       push,
    output mvm_pkg::cmd_t                              cmd,
    output logic [(MAX_N > 1 ? $clog2(MAX_N) : 1)-1:0] cmd_addr
);

    import mvm_pkg::*;

    localparam int ADDR_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CNT_W  = $clog2(MAX_N + 1);

    logic [ADDR_W-1:0] load_ptr_reg, load_ptr_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic [CNT_W-1:0]  eff_len;
    logic [ROW_W-1:0]  eff_rows;
    logic [CNT_W-1:0]  ptr_inc;
    logic [CNT_W-1:0]  col_inc;
    logic              row_done;
    logic              is_last;

    // Clamp the configured lengths into their legal ranges
    always_comb
    begin
        if (vec_len == '0)
            eff_len = CNT_W'(1);
        else if (32'(vec_len) > MAX_N)
            eff_len = CNT_W'(MAX_N);
        else
            eff_len = CNT_W'(vec_len);

        if (row_count == '0)
            eff_rows = ROW_W'(1);
        else if (32'(row_count) > MAX_ROWS)
            eff_rows = ROW_W'(MAX_ROWS);
        else
            eff_rows = row_count;
    end

    // Accept whenever the queue has room
    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    assign ptr_inc  = CNT_W'(load_ptr_reg) + CNT_W'(1);
    assign col_inc  = CNT_W'(col_reg) + CNT_W'(1);
    assign row_done = (col_inc >= eff_len);
    assign is_last  = ({1'b0, row_reg} + 17'd1) >= {1'b0, eff_rows};

    // Classify the item and advance the counters
    always_comb
    begin
        load_ptr_next = load_ptr_reg;
        col_next      = col_reg;
        row_next      = row_reg;

        cmd.op      = opcode;
        cmd.first   = (col_reg == '0);
        cmd.row_end = row_done;
        cmd.last    = is_last;
        cmd.row_idx = row_reg;
        cmd.value   = elem_value;
        cmd_addr    = (opcode == OP_LOAD) ? load_ptr_reg : col_reg;

        if (push)
        begin
            unique case (opcode)
                OP_LOAD:
                begin
                    load_ptr_next = (ptr_inc >= eff_len) ? '0 : ADDR_W'(ptr_inc);
                    col_next      = '0;
                    row_next      = '0;
                end
                OP_WEIGHT:
                begin
                    if (row_done)
                    begin
                        col_next = '0;
                        row_next = is_last ? '0 : row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = ADDR_W'(col_inc);
                    end
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            load_ptr_reg <= load_ptr_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

endmodule

FILE: rtl/core/mvm_queue.sv
// ----------------------------------------------------------------------------
// mvm_queue
// Small flip-flop FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mvm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/mvm_back.sv
// ----------------------------------------------------------------------------
// mvm_back
// Executes queued commands: writes the vector store, reads it for weights,
// multiplies, accumulates and presents each row's dot product.
// ----------------------------------------------------------------------------
module mvm_back #(
    parameter int MAX_N = 4096
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // queue pop side
    input  logic                                       queue_empty,
    input  mvm_pkg::cmd_t                              cmd,
    input  logic [(MAX_N > 1 ? $clog2(MAX_N) : 1)-1:0] cmd_addr,
    output logic                                       pop,
    // result channel
    output logic                                       result_valid,
    input  logic                                       result_stall,
    output logic [mvm_pkg::ROW_W-1:0]                  row_index,
    output logic signed [mvm_pkg::ACC_W-1:0]           dot_value,
    output logic                                       last_row
);

    import mvm_pkg::*;

    localparam int ADDR_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    logic                     adv;
    logic                     is_weight;
    logic [VAL_W-1:0]         vec_rdata;

    // stage 1: vector element being read
    logic                     s1_valid_reg;
    cmd_t                     s1_cmd_reg;
    // stage 2: product
    logic                     s2_valid_reg;
    cmd_t                     s2_cmd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    // accumulator and result
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     res_valid_reg;
    logic [ROW_W-1:0]         res_row_reg;
    logic signed [ACC_W-1:0]  res_dot_reg;
    logic                     res_last_reg;

    // Whole pipeline moves unless a result is held by the consumer
    assign adv       = !res_valid_reg || !result_stall;
    assign pop       = adv && !queue_empty;
    assign is_weight = (cmd.op == OP_WEIGHT);

    mvm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_N)
    ) u_vec_store (
        .clk   (clk),
        .we    (pop && !is_weight),
        .waddr (ADDR_W'(cmd_addr)),
        .wdata (cmd.value),
        .re    (pop && is_weight),
        .raddr (ADDR_W'(cmd_addr)),
        .rdata (vec_rdata)
    );

    // Running sum, restarted on the first column of a row
    always_comb
    begin
        acc_next = (s2_cmd_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    // Control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop && is_weight;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg && s2_cmd_reg.row_end;
            if (s2_valid_reg)
                acc_reg <= acc_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= cmd;
            s2_cmd_reg <= s1_cmd_reg;
            prod_reg   <= $signed(s1_cmd_reg.value) * $signed(vec_rdata);
            if (s2_valid_reg && s2_cmd_reg.row_end)
            begin
                res_row_reg  <= s2_cmd_reg.row_idx;
                res_dot_reg  <= acc_next;
                res_last_reg <= s2_cmd_reg.last;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign row_index    = res_row_reg;
    assign dot_value    = res_dot_reg;
    assign last_row     = res_last_reg;

endmodule

FILE: rtl/core/matrix_vector_multiply_top.sv
// Result path: a row's final weight passes the command queue, the stage 1 read,
//   the stage 2 product and the result register; a result channel stall holds it.
// Throughput: one item per cycle while results are taken; the back end retires
//   one command per cycle (a store write, or a store read and multiply-accumulate).
//   A stalled result freezes the back end; items are taken until the 4-entry queue fills.
// Reset: counters and sum clear, vec_len and row_count return to 1; the
//   vector store is not cleared and must be loaded before weights arrive.
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top
// Streams W(d,n) in row-major order against a stored vector x(n) and returns
// one exact Q24.24 dot product per row.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top #(
    parameter int MAX_N    = 4096,
    parameter int MAX_ROWS = 65535
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]       cfg_data,
    // item channel
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 opcode,
    input  logic signed [mvm_pkg::VAL_W-1:0]     elem_value,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [mvm_pkg::ROW_W-1:0]            row_index,
    output logic signed [mvm_pkg::ACC_W-1:0]     dot_value,
    output logic                                 last_row
);

    import mvm_pkg::*;

    localparam int ADDR_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int ENTRY_W = $bits(cmd_t) + ADDR_W;

    logic [VEC_LEN_W-1:0] vec_len_reg;
    logic [ROW_W-1:0]     row_count_reg;

    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 queue_empty;
    cmd_t                 front_cmd;
    logic [ADDR_W-1:0]    front_addr;
    logic [ENTRY_W-1:0]   head;
    cmd_t                 back_cmd;
    logic [ADDR_W-1:0]    back_addr;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_len_reg   <= VEC_LEN_W'(1);
            row_count_reg <= ROW_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_VEC_LEN:   vec_len_reg   <= cfg_data[VEC_LEN_W-1:0];
                REG_ROW_COUNT: row_count_reg <= cfg_data[ROW_W-1:0];
                default:       vec_len_reg   <= vec_len_reg;
            endcase
        end
    end

    mvm_front #(
        .MAX_N    (MAX_N),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .elem_value (elem_value),
        .vec_len    (vec_len_reg),
        .row_count  (row_count_reg),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (front_cmd),
        .cmd_addr   (front_addr)
    );

    mvm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_cmd, front_addr}),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    assign back_cmd  = head[ENTRY_W-1:ADDR_W];
    assign back_addr = head[ADDR_W-1:0];

    mvm_back #(
        .MAX_N (MAX_N)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .cmd          (back_cmd),
        .cmd_addr     (back_addr),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .row_index    (row_index),
        .dot_value    (dot_value),
        .last_row     (last_row)
    );

endmodule

FILE: rtl/core/mvm_checker.sv
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level assertions for the matrix-vector multiply block.
// ----------------------------------------------------------------------------
module mvm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               item_stall,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic [mvm_pkg::ROW_W-1:0]          row_index,
    input logic signed [mvm_pkg::ACC_W-1:0]   dot_value,
    input logic                               last_row
);

    // No result is shown while reset is applied
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result_valid high during reset");

    // Queue starts empty: items are taken right after reset
    a_ready_after_reset: assert property (@(posedge clk) !$past(rst_n) |-> !item_stall)
        else $error("item_stall high right after reset");

    // Every result passes the queue and the pipeline registers, so none on the first edge out of reset
    a_no_early_result: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !result_valid ##1 !result_valid)
        else $error("result appeared too soon after reset");

    // A stalled result holds its transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(row_index)
            && $stable(dot_value) && $stable(last_row))
        else $error("stalled result changed");

endmodule

bind matrix_vector_multiply_top mvm_checker u_mvm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row_index    (row_index),
    .dot_value    (dot_value),
    .last_row     (last_row)
);
